@@ rtl/core/nstg_pkg.sv @@
// ----------------------------------------------------------------------------
// nstg_pkg: shared types and constants of the note sequence tone generator
// Sizes, register reset values, command and state encodings, sine polynomial
// coefficients and the semitone ratio helpers.
// ----------------------------------------------------------------------------
package nstg_pkg;

  localparam int SEQ_DEPTH        = 256;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int PHASE_BITS       = 32;

  localparam int ADDR_W  = $clog2(SEQ_DEPTH);
  localparam int PTR_W   = $clog2(SEQ_DEPTH + 1);
  localparam int SINE_AW = $clog2(SINE_TABLE_DEPTH);

  // command queue between front and back, power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] A4_INC_RESET   = 32'd39370534;
  localparam logic [23:0] BASE_DUR_RESET = 24'd14400;
  localparam logic [15:0] VOLUME_RESET   = 16'd65535;

  // Q30 odd polynomial for sin over a quarter turn, Horner order
  localparam logic [30:0] SIN_C7   = 31'd5026995;
  localparam logic [30:0] SIN_C5   = 31'd85569306;
  localparam logic [30:0] SIN_C3   = 31'd693598668;
  localparam logic [30:0] SIN_C1   = 31'd1686629713;
  localparam logic [30:0] Q30_ONE  = 31'h4000_0000;

  // floor(y / 5) == (y * RECIP5) >> 18 for every 16-bit y
  localparam logic [16:0] RECIP5   = 17'd52429;
  localparam int          RECIP5_SH = 18;

  typedef enum logic [1:0] {
    CFG_A4_INC   = 2'd0,
    CFG_BASE_DUR = 2'd1,
    CFG_VOLUME   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_START = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ADDR_W-1:0]  addr;
    logic [15:0]        entry;   // {rest, semitone[6:0], duration[7:0]}
    logic [PTR_W-1:0]   length;
  } cmd_t;

  typedef struct packed {
    logic [31:0] a4_inc;
    logic [23:0] base_dur;
    logic [15:0] volume;
  } cfg_t;

  typedef struct packed {
    logic [3:0] k;    // semitone within octave
    logic [4:0] sh;   // right shift, 16 - octave
  } semi_split_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_FETCH,
    B_ENTRY,
    B_U2,
    B_TOT,
    B_INC,
    B_H1,
    B_H1M,
    B_H2,
    B_H2M,
    B_H3,
    B_H3M,
    B_SIN,
    B_VOLM,
    B_VOL,
    B_DIVM,
    B_OUT
  } back_state_t;

  // 2^(k/12) in Q1.16
  function automatic logic [16:0] semi_ratio(input logic [3:0] k);
    logic [16:0] r;
    case (k)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd69433;
      4'd2:    r = 17'd73562;
      4'd3:    r = 17'd77936;
      4'd4:    r = 17'd82570;
      4'd5:    r = 17'd87480;
      4'd6:    r = 17'd92682;
      4'd7:    r = 17'd98193;
      4'd8:    r = 17'd104032;
      4'd9:    r = 17'd110218;
      4'd10:   r = 17'd116772;
      4'd11:   r = 17'd123715;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

  // floor split of semitone s into 12*oct + k; t = s + 72 lies in 8..135,
  // t / 12 by reciprocal 171 / 2048 is exact over that range
  function automatic semi_split_t semi_split(input logic [6:0] sem7);
    logic [7:0]  t;
    logic [15:0] prod;
    logic [3:0]  oq;
    logic [7:0]  rem;
    semi_split_t r;
    t    = {sem7[6], sem7} + 8'd72;
    prod = 16'(t) * 16'd171;
    oq   = 4'(prod >> 11);
    rem  = t - (8'(oq) * 8'd12);
    r.k  = rem[3:0];
    r.sh = 5'd22 - 5'(oq);
    return r;
  endfunction

endpackage

@@ rtl/core/nstg_ram.sv @@
// ----------------------------------------------------------------------------
// nstg_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module nstg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/nstg_front.sv @@
// ----------------------------------------------------------------------------
// nstg_front: command intake and classification
// Decodes the action, packs note entries, saturates the sequence length and
// drops commands that have no effect.
// ----------------------------------------------------------------------------
module nstg_front import nstg_pkg::*; (
  input  logic              start,
  input  logic              full,
  input  logic [1:0]        action,
  input  logic [7:0]        note_index,
  input  logic              is_rest,
  input  logic signed [6:0] semitone,
  input  logic [7:0]        duration_units,
  input  logic [8:0]        seq_length,
  output logic              push,
  output cmd_t              cmd
);

  logic accept;
  logic slot_ok;

  assign accept  = start && !full;
  assign slot_ok = (32'(note_index) < 32'(SEQ_DEPTH));

  always_comb begin
    cmd.kind   = CMD_TICK;
    cmd.addr   = ADDR_W'(note_index);
    cmd.entry  = {is_rest, semitone, duration_units};
    cmd.length = (32'(seq_length) > 32'(SEQ_DEPTH)) ? PTR_W'(SEQ_DEPTH)
                                                    : PTR_W'(seq_length);
    push       = 1'b0;
    unique case (action)
      ACT_WRITE: begin
        cmd.kind = CMD_WRITE;
        push     = accept && slot_ok;
      end
      ACT_START: begin
        cmd.kind = CMD_START;
        push     = accept;
      end
      ACT_TICK: begin
        cmd.kind = CMD_TICK;
        push     = accept;
      end
      default: begin
        push = 1'b0;   // undefined action, swallowed
      end
    endcase
  end

endmodule

@@ rtl/core/nstg_queue.sv @@
// ----------------------------------------------------------------------------
// nstg_queue: short command FIFO between front and back
// Register-based, simultaneous push and pop allowed.
// ----------------------------------------------------------------------------
module nstg_queue import nstg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t dout
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign dout    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

@@ rtl/core/nstg_back.sv @@
// ----------------------------------------------------------------------------
// nstg_back: command execution and sample synthesis
// Owns the note table, playback state and phase accumulator; computes each
// sample with one shared 32x32 multiplier stepped by a sequencer.
// ----------------------------------------------------------------------------
module nstg_back import nstg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        res_valid,
  output logic [15:0] res_sample,
  output logic [7:0]  res_index,
  output logic        res_done
);

  back_state_t state;
  back_state_t state_next;

  // playback state
  logic [PTR_W-1:0]      play_ptr;
  logic [PTR_W-1:0]      len_use;
  logic [31:0]           samples_in_note;
  logic [PHASE_BITS-1:0] phase;
  logic                  finished;

  // per-tick working registers
  logic [15:0]           entry;
  logic [30:0]           u;
  logic [1:0]            quad;
  logic [30:0]           u2;
  logic [31:0]           total;
  semi_split_t           semi;
  logic [PHASE_BITS-1:0] inc;
  logic [30:0]           horner;
  logic [30:0]           sin_q30;
  logic [15:0]           y;

  // shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  // note table
  logic              ram_we;
  logic [15:0]       ram_rdata;

  logic                  end_of_seq;
  logic [SINE_AW-1:0]    idx;
  logic [1:0]            quad_c;
  logic [30:0]           u_raw;
  logic [30:0]           u_c;
  logic [30:0]           hi30;
  logic [61:0]           x_scaled;
  logic [13:0]           mag;
  logic [15:0]           sample_c;
  logic [32:0]           done_count;
  logic                  note_end;
  logic [PTR_W-1:0]      ptr_inc;

  nstg_ram #(
    .WIDTH (16),
    .DEPTH (SEQ_DEPTH)
  ) u_note_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_cmd.addr),
    .wdata (q_cmd.entry),
    .raddr (play_ptr[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign end_of_seq = finished || (play_ptr >= len_use);

  // phase to quarter-wave argument in Q30
  assign idx    = phase[PHASE_BITS-1 -: SINE_AW];
  assign quad_c = idx[SINE_AW-1 -: 2];
  assign u_raw  = 31'(idx[SINE_AW-3:0]) << (32 - SINE_AW);
  assign u_c    = quad_c[0] ? (Q30_ONE - u_raw) : u_raw;

  assign hi30     = mul_p[60:30];
  assign x_scaled = (62'(mul_p[45:0]) << 15) - 62'(mul_p[45:0]);  // * 32767
  assign mag      = mul_p[RECIP5_SH +: 14];
  assign sample_c = entry[15] ? 16'd0
                  : (quad[1] ? (16'd0 - 16'(mag)) : 16'(mag));

  assign done_count = 33'(samples_in_note) + 33'd1;
  assign note_end   = (done_count >= 33'(total));
  assign ptr_inc    = play_ptr + 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid && (q_cmd.kind == CMD_TICK) && !end_of_seq) begin
          state_next = B_FETCH;
        end
      end
      B_FETCH: state_next = B_ENTRY;
      B_ENTRY: state_next = B_U2;
      B_U2:    state_next = B_TOT;
      B_TOT:   state_next = B_INC;
      B_INC:   state_next = B_H1;
      B_H1:    state_next = B_H1M;
      B_H1M:   state_next = B_H2;
      B_H2:    state_next = B_H2M;
      B_H2M:   state_next = B_H3;
      B_H3:    state_next = B_H3M;
      B_H3M:   state_next = B_SIN;
      B_SIN:   state_next = B_VOLM;
      B_VOLM:  state_next = B_VOL;
      B_VOL:   state_next = B_DIVM;
      B_DIVM:  state_next = B_OUT;
      B_OUT:   state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs: queue pop, table write, multiplier operands
  always_comb begin
    q_pop  = 1'b0;
    ram_we = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      B_IDLE: begin
        q_pop  = q_valid;
        ram_we = q_valid && (q_cmd.kind == CMD_WRITE);
      end
      B_ENTRY: begin
        mul_a = 32'(u);
        mul_b = 32'(u);
      end
      B_U2: begin
        mul_a = 32'(entry[7:0]);
        mul_b = 32'(cfg.base_dur);
      end
      B_TOT: begin
        mul_a = cfg.a4_inc;
        mul_b = 32'(semi_ratio(semi.k));
      end
      B_INC: begin
        mul_a = 32'(SIN_C7);
        mul_b = 32'(u2);
      end
      B_H1M, B_H2M: begin
        mul_a = 32'(horner);
        mul_b = 32'(u2);
      end
      B_H3M: begin
        mul_a = 32'(horner);
        mul_b = 32'(u);
      end
      B_VOLM: begin
        mul_a = 32'(sin_q30);
        mul_b = 32'(cfg.volume);
      end
      B_DIVM: begin
        mul_a = 32'(y);
        mul_b = 32'(RECIP5);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= B_IDLE;
      play_ptr        <= '0;
      len_use         <= '0;
      samples_in_note <= '0;
      phase           <= '0;
      finished        <= 1'b1;
      res_valid       <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= 1'b0;
      if (state == B_IDLE && q_valid) begin
        if (q_cmd.kind == CMD_START) begin
          len_use         <= q_cmd.length;
          play_ptr        <= '0;
          samples_in_note <= '0;
          phase           <= '0;
          finished        <= 1'b0;
        end else if (q_cmd.kind == CMD_TICK && end_of_seq) begin
          finished  <= 1'b1;
          res_valid <= 1'b1;
        end
      end
      if (state == B_OUT) begin
        res_valid <= 1'b1;
        if (note_end) begin
          play_ptr        <= ptr_inc;
          samples_in_note <= '0;
          phase           <= '0;
          if (ptr_inc >= len_use) begin
            finished <= 1'b1;
          end
        end else begin
          samples_in_note <= done_count[31:0];
          if (!entry[15]) begin
            phase <= phase + inc;
          end
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    case (state)
      B_IDLE: begin
        res_sample <= 16'd0;
        res_index  <= 8'd0;
        res_done   <= 1'b1;
      end
      B_FETCH: begin
        u    <= u_c;
        quad <= quad_c;
      end
      B_ENTRY: entry <= ram_rdata;
      B_U2: begin
        u2   <= hi30;
        semi <= semi_split(entry[14:8]);
      end
      B_TOT:   total   <= mul_p[31:0];
      B_INC:   inc     <= PHASE_BITS'(mul_p >> semi.sh);
      B_H1:    horner  <= SIN_C5 - hi30;
      B_H2:    horner  <= SIN_C3 - hi30;
      B_H3:    horner  <= SIN_C1 - hi30;
      B_SIN:   sin_q30 <= (hi30 > Q30_ONE) ? Q30_ONE : hi30;
      B_VOL:   y       <= 16'(x_scaled >> 46);
      B_OUT: begin
        res_sample <= sample_c;
        res_index  <= 8'(play_ptr);
        res_done   <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/note_sequence_tone_generator_core.sv @@
// ----------------------------------------------------------------------------
// note_sequence_tone_generator_core: sine tone sequencer, top level
// Plays a table of notes as 16-bit PCM, one sample per tick command.
// ----------------------------------------------------------------------------
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------
//  command   | start / busy            | action, note_index, is_rest,
//            |                         | semitone, duration_units, seq_length
//  config    | cfg_valid / cfg_ready   | cfg_index, cfg_data
//  result    | result_valid (strobe)   | sample, playing_index, done_res
//
// A command transfers on a clock edge with start high and busy low; it goes
// through a two-entry queue, so busy rises only when two commands wait.
// Note writes and start are handled in the idle state; a tick that plays a
// note runs the table read, then nine registered passes through the one
// shared 32x32 multiplier (five for the sine polynomial, one each for gain,
// divide by five, duration and pitch step). A tick after the sequence ended
// is answered from the idle state and reports done.
// Results are strobed for one cycle and cannot be stalled.
// Synchronous reset clears playback state; the note table is not cleared.
// Config has no wait states (cfg_ready is tied high).
// ----------------------------------------------------------------------------
module note_sequence_tone_generator_core import nstg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [7:0]         note_index,
  input  logic               is_rest,
  input  logic signed [6:0]  semitone,
  input  logic [7:0]         duration_units,
  input  logic [8:0]         seq_length,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // result channel
  output logic               result_valid,
  output logic signed [15:0] sample,
  output logic [7:0]         playing_index,
  output logic               done_res
);

  cfg_t  cfg;
  logic  q_full;
  logic  front_push;
  cmd_t  front_cmd;
  logic  q_valid;
  cmd_t  q_cmd;
  logic  q_pop;
  logic [15:0] res_sample;

  assign busy      = q_full;
  assign cfg_ready = 1'b1;

  // configuration registers; a write lands on any cycle with cfg_valid high
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a4_inc   <= A4_INC_RESET;
      cfg.base_dur <= BASE_DUR_RESET;
      cfg.volume   <= VOLUME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_A4_INC:   cfg.a4_inc   <= cfg_data;
        CFG_BASE_DUR: cfg.base_dur <= cfg_data[23:0];
        CFG_VOLUME:   cfg.volume   <= cfg_data[15:0];
        default: begin
          // unmapped index, dropped
        end
      endcase
    end
  end

  // front: decode and classify the incoming command
  nstg_front u_front (
    .start          (start),
    .full           (q_full),
    .action         (action),
    .note_index     (note_index),
    .is_rest        (is_rest),
    .semitone       (semitone),
    .duration_units (duration_units),
    .seq_length     (seq_length),
    .push           (front_push),
    .cmd            (front_cmd)
  );

  // decoupling queue
  nstg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .din   (front_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_cmd)
  );

  // back: table, playback state, sample arithmetic
  nstg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .res_valid  (result_valid),
    .res_sample (res_sample),
    .res_index  (playing_index),
    .res_done   (done_res)
  );

  assign sample = signed'(res_sample);

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for note_sequence_tone_generator_core
// Sends note writes, start commands and sample ticks through the start/busy
// channel and reprograms the gain, pitch and duration registers between
// phases. A behavioral copy of the sequencer predicts every tick result, and
// each strobed result is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module testbench;
  import nstg_pkg::*;

  localparam int          CLK_HALF   = 5;
  localparam int          RST_CYCLES = 5;
  localparam int          DRAIN_WAIT = 40;        // > queue + tick path
  localparam int          CYCLE_MAX  = 1_000_000;
  localparam int          RAND_ITEMS = 1400;
  localparam int          NUM_PHASES = 6;
  localparam int          PRINT_MAX  = 200;
  localparam logic [1:0]  ACT_NONE   = 2'd3;      // undefined command code

  // 2^(k/12) in Q1.16, entry k at [k]
  localparam logic [11:0][16:0] RATIO_Q16 = {
    17'd123715, 17'd116772, 17'd110218, 17'd104032, 17'd98193, 17'd92682,
    17'd87480,  17'd82570,  17'd77936,  17'd73562,  17'd69433, 17'd65536
  };

  typedef struct packed {
    logic [15:0] smp;
    logic [7:0]  idx;
    logic        done;
  } tone_result_t;

  // DUT signals
  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         action;
  logic [7:0]         note_index;
  logic               is_rest;
  logic signed [6:0]  semitone;
  logic [7:0]         duration_units;
  logic [8:0]         seq_length;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               result_valid;
  logic signed [15:0] sample;
  logic [7:0]         playing_index;
  logic               done_res;

  // behavioral copy of the sequencer
  logic [31:0]  a4_step;
  logic [23:0]  unit_len;
  logic [15:0]  gain;
  logic [15:0]  notes_model [SEQ_DEPTH];
  int unsigned  note_ptr;
  int unsigned  seq_len;
  logic [31:0]  note_ticks;
  logic [31:0]  phase_acc;
  bit           seq_over;

  tone_result_t expected_samples [$];

  // bench bookkeeping
  int  err_count   = 0;
  int  cycle_count = 0;
  int  items_sent  = 0;
  int  burst_left  = 0;
  bit  start_high  = 1'b0;

  note_sequence_tone_generator_core uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .note_index     (note_index),
    .is_rest        (is_rest),
    .semitone       (semitone),
    .duration_units (duration_units),
    .seq_length     (seq_length),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .result_valid   (result_valid),
    .sample         (sample),
    .playing_index  (playing_index),
    .done_res       (done_res)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // per-tick phase step: floor split of the semitone into octave and
  // position within octave, ratio from the table, octave as a shift
  function automatic logic [31:0] pitch_step(input logic [6:0] sem);
    int                s;
    int                t;
    int                oct;
    int                k;
    longint unsigned   prod;
    s    = $signed(sem);
    t    = s + 72;                       // always positive, so / and % floor
    oct  = t / 12 - 6;
    k    = t % 12;
    prod = 64'(a4_step) * 64'(RATIO_Q16[k]);
    return 32'(prod >> (16 - oct));
  endfunction

  // quarter-wave Q30 polynomial sine, scaled by 0.2 * gain * full scale
  function automatic logic [15:0] sine_level(input logic [31:0] ph);
    longint unsigned idx;
    longint unsigned quad;
    longint unsigned rem;
    longint unsigned u;
    longint unsigned u2;
    longint unsigned r;
    longint unsigned mag;
    longint unsigned one_q30;
    one_q30 = 64'd1 << 30;
    idx  = (64'(ph) * SINE_TABLE_DEPTH) >> PHASE_BITS;
    quad = (idx * 4) / SINE_TABLE_DEPTH;
    rem  = idx * 4 - quad * SINE_TABLE_DEPTH;
    u    = (rem << 30) / SINE_TABLE_DEPTH;
    if (quad[0]) u = one_q30 - u;       // mirror on odd quadrants
    u2 = (u * u) >> 30;
    r  = 64'd5026995;
    r  = 64'd85569306   - ((r * u2) >> 30);
    r  = 64'd693598668  - ((r * u2) >> 30);
    r  = 64'd1686629713 - ((r * u2) >> 30);
    r  = (r * u) >> 30;
    if (r > one_q30) r = one_q30;
    mag = ((r * 64'(gain) * 64'd32767) / 64'd5) >> 46;
    if (quad[1]) return 16'(64'd0 - mag);
    return 16'(mag);
  endfunction

  // one sample tick: expected result plus the state advance
  task automatic play_tick();
    tone_result_t    res;
    logic [15:0]     entry;
    longint unsigned total;
    if (seq_over || note_ptr >= seq_len || note_ptr >= SEQ_DEPTH) begin
      seq_over = 1'b1;
      res = '{smp: 16'd0, idx: 8'd0, done: 1'b1};
    end else begin
      entry = notes_model[note_ptr];
      res   = '{smp: 16'd0, idx: 8'(note_ptr), done: 1'b0};
      if (!entry[15]) begin
        res.smp   = sine_level(phase_acc);
        phase_acc = phase_acc + pitch_step(entry[14:8]);
      end
      // zero length still ends the note after this tick
      total = 64'(entry[7:0]) * 64'(unit_len);
      if (64'(note_ticks) + 64'd1 >= total) begin
        note_ptr++;
        note_ticks = '0;
        phase_acc  = '0;
        if (note_ptr >= seq_len) seq_over = 1'b1;
      end else begin
        note_ticks = note_ticks + 32'd1;
      end
    end
    expected_samples.push_back(res);
  endtask

  task automatic predict_cmd(input logic [1:0] a, input logic [7:0] idx,
                             input logic [15:0] entry, input logic [8:0] len);
    case (a)
      ACT_WRITE: notes_model[idx] = entry;
      ACT_START: begin
        seq_len    = (len > SEQ_DEPTH) ? SEQ_DEPTH : len;   // saturate
        note_ptr   = 0;
        note_ticks = '0;
        phase_acc  = '0;
        seq_over   = 1'b0;
      end
      ACT_TICK:  play_tick();
      default: ;                                          // ignored code
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Command sender: bursts of random length separated by random gaps.
  // start is only lowered when a gap opens, so back-to-back transfers keep
  // it high without a second assignment in the same step.
  // --------------------------------------------------------------------------
  task automatic sender_idle();
    if (start_high) begin
      start      <= 1'b0;
      start_high  = 1'b0;
    end
    burst_left = 0;
  endtask

  task automatic send_cmd(input logic [1:0] a, input logic [7:0] idx,
                          input logic [15:0] entry, input logic [8:0] len);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        sender_idle();
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 12);
    end
    burst_left--;
    start          <= 1'b1;
    start_high      = 1'b1;
    action         <= a;
    note_index     <= idx;
    is_rest        <= entry[15];
    semitone       <= entry[14:8];
    duration_units <= entry[7:0];
    seq_length     <= len;
    // transfer on the first edge that sees busy low
    do @(posedge clk); while (busy !== 1'b0);
    predict_cmd(a, idx, entry, len);
    if (a != ACT_NONE) items_sent++;
  endtask

  task automatic write_note(input logic [7:0] idx, input logic [15:0] entry);
    send_cmd(ACT_WRITE, idx, entry, 9'($urandom));
  endtask

  task automatic start_seq(input logic [8:0] len);
    send_cmd(ACT_START, 8'($urandom), 16'($urandom), len);
  endtask

  // other fields are don't-care on a tick; keep them moving
  task automatic tick(input int n);
    repeat (n) send_cmd(ACT_TICK, 8'($urandom), 16'($urandom), 9'($urandom));
  endtask

  // let every expected sample come back, then cover the write/start path
  task automatic wait_drained();
    sender_idle();
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // register write; only called with the core drained
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_A4_INC:   a4_step  = data;
      CFG_BASE_DUR: unit_len = data[23:0];
      CFG_VOLUME:   gain     = data[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] a4, input logic [23:0] unit,
                            input logic [15:0] vol);
    wait_drained();
    write_reg(CFG_A4_INC, a4);
    write_reg(CFG_BASE_DUR, 32'(unit));
    write_reg(CFG_VOLUME, 32'(vol));
  endtask

  // random table entry: mostly short tones, some rests, the odd long note
  function automatic logic [15:0] rand_note();
    logic [7:0] dur;
    case ($urandom_range(0, 9))
      0:       dur = 8'd0;
      1:       dur = 8'd255;
      2:       dur = 8'($urandom);
      default: dur = 8'($urandom_range(1, 3));
    endcase
    return {($urandom_range(0, 4) == 0), 7'($urandom), dur};
  endfunction

  function automatic logic [8:0] rand_len();
    case ($urandom_range(0, 9))
      0:       return 9'd0;
      1:       return 9'($urandom_range(256, 511));
      default: return 9'($urandom_range(1, 6));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: results cannot be held off, so every strobe is taken on
  // the edge that ends it and matched against the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_MAX)
      $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  always @(posedge clk) begin
    tone_result_t exp_res;
    if (!rst && result_valid === 1'b1) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("result strobe with no tick outstanding");
      end else begin
        exp_res = expected_samples.pop_front();
        if (sample !== exp_res.smp)
          report_mismatch($sformatf("sample %0d, expected %0d",
                                    sample, $signed(exp_res.smp)));
        if (playing_index !== exp_res.idx)
          report_mismatch($sformatf("playing_index %0d, expected %0d",
                                    playing_index, exp_res.idx));
        if (done_res !== exp_res.done)
          report_mismatch($sformatf("done_res %0b, expected %0b",
                                    done_res, exp_res.done));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_MAX) begin
      $display("note_sequence_tone_generator_core: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // out of reset the sequencer is finished: ticks report done; code 3 is a
  // no-op and must not produce a strobe
  task automatic test_idle_after_reset();
    tick(2);
    send_cmd(ACT_NONE, 8'($urandom), 16'($urandom), 9'($urandom));
    tick(1);
  endtask

  // pitch extremes, rest, zero-length note and the top duration
  task automatic test_pitch_and_rest();
    set_config(A4_INC_RESET, 24'd1, 16'hFFFF);
    write_note(8'd0, {1'b0, 7'sd0,   8'd2});
    write_note(8'd1, {1'b0, -7'sd64, 8'd1});   // lowest field value, wraps
    write_note(8'd2, {1'b0, 7'sd63,  8'd1});   // highest field value
    write_note(8'd3, {1'b1, 7'sd5,   8'd1});   // rest
    write_note(8'd4, {1'b0, 7'sd12,  8'd0});   // zero length, one tick
    write_note(8'd5, {1'b0, -7'sd1,  8'd255});
    start_seq(9'd6);
    tick(9);
  endtask

  // start with nothing to play, then keep ticking past the end
  task automatic test_empty_sequence();
    start_seq(9'd0);
    tick(2);
  endtask

  // fill every slot so any later length is safe to play
  task automatic test_table_fill();
    for (int i = 0; i < SEQ_DEPTH; i++) write_note(8'(i), rand_note());
  endtask

  // lengths past the table saturate to the table depth
  task automatic test_long_sequence();
    set_config(A4_INC_RESET, 24'd1, 16'hFFFF);
    start_seq(9'd511);
    tick(6);
    start_seq(9'd256);
    tick(3);
  endtask

  // phases of random traffic, each under its own register setting
  task automatic test_random_play();
    int per_phase;
    int stop_at;
    int ticks;
    per_phase = RAND_ITEMS / NUM_PHASES;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_config($urandom, 24'd1, 16'hFFFF);
        1: set_config(32'd0, 24'd2, 16'($urandom));
        2: set_config(32'hFFFF_FFFF, 24'd1, 16'd0);
        3: set_config($urandom, 24'hFF_FFFF, 16'hFFFF);   // only zero-length notes end
        4: set_config($urandom, 24'($urandom_range(1, 4)), 16'($urandom));
        default: set_config(A4_INC_RESET, 24'd3, 16'h8000);
      endcase
      stop_at = items_sent + per_phase;
      while (items_sent < stop_at) begin
        case ($urandom_range(0, 9))
          7: begin                               // single stray command
            case ($urandom_range(0, 3))
              0: write_note(8'($urandom), rand_note());
              1: start_seq(rand_len());
              2: tick(1);
              default: send_cmd(ACT_NONE, 8'($urandom), 16'($urandom),
                                9'($urandom));
            endcase
          end
          8: begin                               // restart in mid-note
            start_seq(rand_len());
            tick($urandom_range(1, 4));
          end
          9: wait_drained();                     // drain before going on
          default: begin                         // write, start, play
            repeat ($urandom_range(0, 4)) write_note(8'($urandom), rand_note());
            start_seq(rand_len());
            ticks = $urandom_range(1, 25);
            tick(ticks);
          end
        endcase
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst            <= 1'b1;
    start          <= 1'b0;
    action         <= ACT_WRITE;
    note_index     <= '0;
    is_rest        <= 1'b0;
    semitone       <= '0;
    duration_units <= '0;
    seq_length     <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_A4_INC;
    cfg_data       <= '0;

    // power-on register values and playback state
    a4_step    = A4_INC_RESET;
    unit_len   = BASE_DUR_RESET;
    gain       = VOLUME_RESET;
    note_ptr   = 0;
    seq_len    = 0;
    note_ticks = '0;
    phase_acc  = '0;
    seq_over   = 1'b1;
    for (int i = 0; i < SEQ_DEPTH; i++) notes_model[i] = '0;

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_after_reset();
    test_pitch_and_rest();
    test_empty_sequence();
    test_table_fill();
    test_long_sequence();
    test_random_play();

    // all commands transferred: drain, then watch for stray strobes
    wait_drained();
    if (err_count == 0) begin
      $display("note_sequence_tone_generator_core: match");
    end else begin
      $display("note_sequence_tone_generator_core: mismatch");
    end
    $finish;
  end

endmodule
